// File: hw/rtl/c3r_pkg.sv
// Package for the streaming 3x3 int8 convolution with ReLU.
// Holds sizes, codes, state encoding and the structs shared between modules.
// No dependencies.
package c3r_pkg;

    localparam int HEIGHT       = 32;
    localparam int WIDTH        = 32;
    localparam int OUT_CHANNELS = 32;
    localparam int LANES        = 8;
    localparam int TAPS         = 27;
    localparam int NGROUPS      = (OUT_CHANNELS + LANES - 1) / LANES;
    localparam int OUT_LANES    = 8;

    localparam int ROW_W   = $clog2(HEIGHT);
    localparam int COL_W   = $clog2(WIDTH);
    localparam int GRP_W   = (NGROUPS > 1) ? $clog2(NGROUPS) : 1;
    localparam int LANE_W  = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int OC_W    = $clog2(OUT_CHANNELS + 1);
    localparam int WADDR_W = $clog2(NGROUPS * TAPS);
    localparam int IDX_W   = 10;
    localparam int PIX_W   = 24;
    localparam int LINE_W  = 2 * PIX_W;
    localparam int ACC_W   = 32;
    localparam int ACT_W   = 7;
    localparam int SH_W    = 5;
    localparam int POS_W   = 5;
    localparam int CG_W    = 2;

    // index / TAPS by reciprocal; exact for any 10-bit index
    localparam int RECIP_SH = 15;
    localparam int RECIP    = (1 << RECIP_SH) / TAPS + 1;
    localparam int RECIP_W  = IDX_W + RECIP_SH;

    localparam logic [SH_W-1:0]  SHIFT_RESET = SH_W'(8);
    localparam logic [ACT_W-1:0] ACT_MAX     = ACT_W'(127);

    typedef enum logic [1:0] {
        MODE_WEIGHT = 2'd0,
        MODE_BIAS   = 2'd1,
        MODE_PIXEL  = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LINE,
        S_SEL,
        S_RUN,
        S_DRAIN
    } t_state;

    typedef struct packed {
        logic               we_w;
        logic               we_b;
        logic [WADDR_W-1:0] waddr;
        logic [GRP_W-1:0]   baddr;
        logic [7:0]         wdata;
        logic [ACC_W-1:0]   bdata;
    } t_lane_wr;

    typedef struct packed {
        logic              en;
        logic              first;
        logic              tap_ok;
        logic signed [7:0] sample;
    } t_mac_ctl;

    typedef struct packed {
        logic             fin;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic [GRP_W-1:0] grp;
        logic             last;
    } t_res_info;

endpackage

// File: hw/rtl/c3r_if.sv
// Channel interfaces of the convolution block: pixel/load input, result output
// and the shift register write port. No dependencies.
interface c3r_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        mode;
    logic [9:0]        index;
    logic signed [31:0] value;
    logic signed [7:0] pix_c0;
    logic signed [7:0] pix_c1;
    logic signed [7:0] pix_c2;

    modport source (output valid, mode, index, value, pix_c0, pix_c1, pix_c2, input ready);
    modport sink   (input valid, mode, index, value, pix_c0, pix_c1, pix_c2, output ready);
endinterface

interface c3r_out_if;
    logic       valid;
    logic       ready;
    logic [4:0] out_row;
    logic [4:0] out_col;
    logic [1:0] chan_group;
    logic [6:0] lane0;
    logic [6:0] lane1;
    logic [6:0] lane2;
    logic [6:0] lane3;
    logic [6:0] lane4;
    logic [6:0] lane5;
    logic [6:0] lane6;
    logic [6:0] lane7;
    logic       run_last;

    modport source (output valid, out_row, out_col, chan_group, lane0, lane1, lane2, lane3,
                    lane4, lane5, lane6, lane7, run_last, input ready);
    modport sink   (input valid, out_row, out_col, chan_group, lane0, lane1, lane2, lane3,
                    lane4, lane5, lane6, lane7, run_last, output ready);
endinterface

interface c3r_cfg_if;
    logic       valid;
    logic       ready;
    logic [4:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// File: hw/rtl/int8_conv3x3_relu_stream.sv
// Top level of the streaming 3x3 int8 convolution with ReLU: sequencer,
// window, line buffer and lane array. Depends on c3r_pkg, c3r_if, c3r_ram,
// c3r_lane and c3r_merge.
//
// Weight and bias load items are written to the lane RAMs as they are
// accepted. A pixel item updates the window and line buffer in S_LINE, then
// each result it causes (0 to 4 positions, one result per group of 8 channels,
// so up to 16) runs 27 tap steps in S_RUN, one per cycle on each lane's single
// weight RAM port, then drains the MAC in S_DRAIN and selects the next group
// or position in S_SEL. A new group starts only once the previous result has
// been taken. No new item is accepted until all results of a pixel are
// computed; the shift register may be written at any time it is idle.
module int8_conv3x3_relu_stream (
    input  logic       i_clk,
    input  logic       i_rst_n,
    c3r_in_if.sink     i_pix,
    c3r_cfg_if.sink    i_cfg,
    c3r_out_if.source  o_res
);

    c3r_pkg::t_state                r_state;
    c3r_pkg::t_state                n_state;
    logic [c3r_pkg::SH_W-1:0]       r_shift;
    logic [c3r_pkg::ROW_W-1:0]      r_row;
    logic [c3r_pkg::COL_W-1:0]      r_col;
    logic [c3r_pkg::ROW_W-1:0]      r_pr;
    logic [c3r_pkg::COL_W-1:0]      r_pc;
    logic [c3r_pkg::PIX_W-1:0]      r_pix;
    logic [c3r_pkg::PIX_W-1:0]      r_win [3][3];
    logic [3:0]                     r_mask;
    logic                           r_more;
    logic                           r_lastpos;
    logic [c3r_pkg::ROW_W-1:0]      r_oh;
    logic [c3r_pkg::COL_W-1:0]      r_ow;
    logic                           r_dr;
    logic                           r_dc;
    logic [c3r_pkg::GRP_W-1:0]      r_grp;
    logic [c3r_pkg::WADDR_W-1:0]    r_waddr;
    logic [1:0]                     r_ic;
    logic [1:0]                     r_kh;
    logic [1:0]                     r_kw;
    c3r_pkg::t_mac_ctl              r_ctl;
    c3r_pkg::t_mac_ctl              n_ctl;
    logic                           r_fin1;
    logic                           r_fin2;

    logic                           in_acc;
    logic                           in_ready;
    logic                           line_we;
    logic [c3r_pkg::LINE_W-1:0]     line_rdata;
    logic [c3r_pkg::LINE_W-1:0]     line_wdata;
    logic                           out_busy;
    logic                           last_tap;
    logic                           start_grp;
    logic                           start_pos;
    logic [1:0]                     pick;
    logic [3:0]                     mask_left;
    logic [3:0]                     n_mask;
    logic [c3r_pkg::GRP_W-1:0]      grp_new;

    logic [c3r_pkg::RECIP_W-1:0]    w_q;
    logic [c3r_pkg::OC_W-1:0]       w_oc;
    logic [c3r_pkg::IDX_W-1:0]      w_tap;
    logic                           w_ok;
    logic                           b_ok;
    c3r_pkg::t_lane_wr              lane_wr [c3r_pkg::LANES];
    logic [c3r_pkg::ACT_W-1:0]      lane_act [c3r_pkg::LANES];
    c3r_pkg::t_res_info             res_info;

    logic [1:0]                     wr_i;
    logic [1:0]                     wc_i;
    logic [c3r_pkg::PIX_W-1:0]      tap_pix;
    logic                           tap_ok;

    assign in_acc   = i_pix.valid && in_ready;
    assign out_busy = o_res.valid;
    assign last_tap = (r_ic == 2'd2) && (r_kh == 2'd2) && (r_kw == 2'd2);

    // ---------------- load decode ----------------
    always_comb begin
        w_q   = c3r_pkg::RECIP_W'(i_pix.index) * c3r_pkg::RECIP_W'(c3r_pkg::RECIP);
        w_oc  = c3r_pkg::OC_W'(w_q >> c3r_pkg::RECIP_SH);
        w_tap = i_pix.index - c3r_pkg::IDX_W'(w_oc * c3r_pkg::TAPS);
        w_ok  = in_acc && (i_pix.mode == c3r_pkg::MODE_WEIGHT)
                && (int'(i_pix.index) < c3r_pkg::OUT_CHANNELS * c3r_pkg::TAPS);
        b_ok  = in_acc && (i_pix.mode == c3r_pkg::MODE_BIAS)
                && (int'(i_pix.index) < c3r_pkg::OUT_CHANNELS);
        for (int l = 0; l < c3r_pkg::LANES; l++) begin
            lane_wr[l].we_w  = w_ok && (c3r_pkg::LANE_W'(w_oc % c3r_pkg::LANES)
                                        == c3r_pkg::LANE_W'(l));
            lane_wr[l].we_b  = b_ok && (c3r_pkg::LANE_W'(i_pix.index % c3r_pkg::LANES)
                                        == c3r_pkg::LANE_W'(l));
            lane_wr[l].waddr = c3r_pkg::WADDR_W'((w_oc / c3r_pkg::LANES) * c3r_pkg::TAPS
                                                 + w_tap);
            lane_wr[l].baddr = c3r_pkg::GRP_W'(i_pix.index / c3r_pkg::LANES);
            lane_wr[l].wdata = i_pix.value[7:0];
            lane_wr[l].bdata = i_pix.value;
        end
    end

    // ---------------- line buffer: low half two rows up, high half one row up
    c3r_ram #(.DATA_W(c3r_pkg::LINE_W), .DEPTH(c3r_pkg::WIDTH)) u_line (
        .i_clk   (i_clk),
        .i_we    (line_we),
        .i_waddr (r_col),
        .i_wdata (line_wdata),
        .i_raddr (r_col),
        .o_rdata (line_rdata)
    );

    assign line_wdata = {r_pix, line_rdata[c3r_pkg::LINE_W-1:c3r_pkg::PIX_W]};

    // ---------------- position selection ----------------
    always_comb begin
        n_mask[0] = (r_row != '0) && (r_col != '0);
        n_mask[1] = (r_row != '0) && (r_col == c3r_pkg::COL_W'(c3r_pkg::WIDTH - 1));
        n_mask[2] = (r_row == c3r_pkg::ROW_W'(c3r_pkg::HEIGHT - 1)) && (r_col != '0);
        n_mask[3] = (r_row == c3r_pkg::ROW_W'(c3r_pkg::HEIGHT - 1))
                    && (r_col == c3r_pkg::COL_W'(c3r_pkg::WIDTH - 1));
        if (r_mask[0]) begin
            pick = 2'd0;
        end else if (r_mask[1]) begin
            pick = 2'd1;
        end else if (r_mask[2]) begin
            pick = 2'd2;
        end else begin
            pick = 2'd3;
        end
        mask_left       = r_mask;
        mask_left[pick] = 1'b0;
        start_grp = (r_state == c3r_pkg::S_SEL) && r_more && !out_busy;
        start_pos = (r_state == c3r_pkg::S_SEL) && !r_more && (r_mask != '0) && !out_busy;
        grp_new   = start_grp ? r_grp + 1'b1 : '0;
    end

    // ---------------- tap select ----------------
    always_comb begin
        wr_i    = r_kh + {1'b0, r_dr};
        wc_i    = r_kw + {1'b0, r_dc};
        tap_pix = '0;
        if (wr_i != 2'd3 && wc_i != 2'd3) begin
            tap_pix = r_win[wr_i][wc_i];
        end
        tap_ok = !((r_oh == '0) && (r_kh == 2'd0))
              && !((r_oh == c3r_pkg::ROW_W'(c3r_pkg::HEIGHT - 1)) && (r_kh == 2'd2))
              && !((r_ow == '0) && (r_kw == 2'd0))
              && !((r_ow == c3r_pkg::COL_W'(c3r_pkg::WIDTH - 1)) && (r_kw == 2'd2))
              && (wr_i != 2'd3) && (wc_i != 2'd3);
        n_ctl.en     = (r_state == c3r_pkg::S_RUN);
        n_ctl.first  = (r_ic == 2'd0) && (r_kh == 2'd0) && (r_kw == 2'd0);
        n_ctl.tap_ok = tap_ok;
        case (r_ic)
            2'd0:    n_ctl.sample = tap_pix[7:0];
            2'd1:    n_ctl.sample = tap_pix[15:8];
            2'd2:    n_ctl.sample = tap_pix[23:16];
            default: n_ctl.sample = '0;
        endcase
    end

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            c3r_pkg::S_IDLE: begin
                if (in_acc && i_pix.mode == c3r_pkg::MODE_PIXEL) begin
                    n_state = c3r_pkg::S_LINE;
                end
            end
            c3r_pkg::S_LINE: begin
                n_state = c3r_pkg::S_SEL;
            end
            c3r_pkg::S_SEL: begin
                if (start_grp || start_pos) begin
                    n_state = c3r_pkg::S_RUN;
                end else if (!r_more && r_mask == '0) begin
                    n_state = c3r_pkg::S_IDLE;
                end
            end
            c3r_pkg::S_RUN: begin
                if (last_tap) begin
                    n_state = c3r_pkg::S_DRAIN;
                end
            end
            c3r_pkg::S_DRAIN: begin
                if (r_fin2) begin
                    n_state = c3r_pkg::S_SEL;
                end
            end
            default: n_state = c3r_pkg::S_IDLE;
        endcase
    end

    // ---------------- outputs of the state machine ----------------
    always_comb begin
        in_ready    = 1'b0;
        line_we     = 1'b0;
        i_cfg.ready = 1'b1;
        case (r_state)
            c3r_pkg::S_IDLE: in_ready = 1'b1;
            c3r_pkg::S_LINE: line_we  = 1'b1;
            default: begin
                in_ready = 1'b0;
                line_we  = 1'b0;
            end
        endcase
    end

    assign i_pix.ready = in_ready;

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= c3r_pkg::S_IDLE;
            r_shift <= c3r_pkg::SHIFT_RESET;
            r_row   <= '0;
            r_col   <= '0;
            r_mask  <= '0;
            r_more  <= 1'b0;
            r_ctl   <= '0;
            r_fin1  <= 1'b0;
            r_fin2  <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[k][j] <= '0;
                end
            end
        end else begin
            r_state <= n_state;
            r_ctl   <= n_ctl;
            r_fin1  <= (r_state == c3r_pkg::S_RUN) && last_tap;
            r_fin2  <= r_fin1;
            if (i_cfg.valid) begin
                r_shift <= i_cfg.data;
            end
            if (r_state == c3r_pkg::S_LINE) begin
                for (int k = 0; k < 3; k++) begin
                    r_win[k][0] <= r_win[k][1];
                    r_win[k][1] <= r_win[k][2];
                end
                r_win[0][2] <= line_rdata[c3r_pkg::PIX_W-1:0];
                r_win[1][2] <= line_rdata[c3r_pkg::LINE_W-1:c3r_pkg::PIX_W];
                r_win[2][2] <= r_pix;
                r_mask      <= n_mask;
                r_more      <= 1'b0;
                if (r_col == c3r_pkg::COL_W'(c3r_pkg::WIDTH - 1)) begin
                    r_col <= '0;
                    r_row <= (r_row == c3r_pkg::ROW_W'(c3r_pkg::HEIGHT - 1))
                             ? '0 : r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
            if (start_pos) begin
                r_mask <= mask_left;
            end
            if (start_grp || start_pos) begin
                r_more <= (grp_new != c3r_pkg::GRP_W'(c3r_pkg::NGROUPS - 1));
            end
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_pix <= {i_pix.pix_c2, i_pix.pix_c1, i_pix.pix_c0};
        end
        if (r_state == c3r_pkg::S_LINE) begin
            r_pr <= r_row;
            r_pc <= r_col;
        end
        if (start_pos) begin
            r_dr      <= pick[1];
            r_dc      <= pick[0];
            r_oh      <= r_pr - {{(c3r_pkg::ROW_W-1){1'b0}}, !pick[1]};
            r_ow      <= r_pc - {{(c3r_pkg::COL_W-1){1'b0}}, !pick[0]};
            r_lastpos <= (mask_left == '0);
        end
        if (start_grp || start_pos) begin
            r_grp   <= grp_new;
            r_waddr <= c3r_pkg::WADDR_W'(grp_new * c3r_pkg::TAPS);
            r_ic    <= '0;
            r_kh    <= '0;
            r_kw    <= '0;
        end else if (r_state == c3r_pkg::S_RUN) begin
            r_waddr <= r_waddr + 1'b1;
            if (r_kw == 2'd2) begin
                r_kw <= '0;
                if (r_kh == 2'd2) begin
                    r_kh <= '0;
                    r_ic <= r_ic + 1'b1;
                end else begin
                    r_kh <= r_kh + 1'b1;
                end
            end else begin
                r_kw <= r_kw + 1'b1;
            end
        end
    end

    // ---------------- lanes ----------------
    for (genvar l = 0; l < c3r_pkg::LANES; l++) begin : g_lane
        c3r_lane u_lane (
            .i_clk     (i_clk),
            .i_wr      (lane_wr[l]),
            .i_raddr_w (r_waddr),
            .i_raddr_b (r_grp),
            .i_ctl     (r_ctl),
            .i_shift   (r_shift),
            .o_act     (lane_act[l])
        );
    end

    always_comb begin
        res_info.fin  = r_fin2;
        res_info.row  = c3r_pkg::POS_W'(r_oh);
        res_info.col  = c3r_pkg::POS_W'(r_ow);
        res_info.grp  = r_grp;
        res_info.last = r_lastpos && (r_grp == c3r_pkg::GRP_W'(c3r_pkg::NGROUPS - 1));
    end

    c3r_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_info  (res_info),
        .i_act   (lane_act),
        .o_res   (o_res)
    );

endmodule

// File: hw/rtl/c3r_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module c3r_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/c3r_lane.sv
// One output-channel lane: weight and bias RAMs for its channels, one MAC
// stepping over the 27 taps, then shift and ReLU clamp. Depends on c3r_pkg, c3r_ram.
module c3r_lane (
    input  logic                          i_clk,
    input  c3r_pkg::t_lane_wr             i_wr,
    input  logic [c3r_pkg::WADDR_W-1:0]   i_raddr_w,
    input  logic [c3r_pkg::GRP_W-1:0]     i_raddr_b,
    input  c3r_pkg::t_mac_ctl             i_ctl,
    input  logic [c3r_pkg::SH_W-1:0]      i_shift,
    output logic [c3r_pkg::ACT_W-1:0]     o_act
);

    logic [7:0]                   w_rdata;
    logic [c3r_pkg::ACC_W-1:0]    b_rdata;
    logic [c3r_pkg::ACC_W-1:0]    r_acc;
    logic [c3r_pkg::ACC_W-1:0]    n_acc;
    logic signed [15:0]           prod;
    logic [c3r_pkg::ACC_W-1:0]    addend;
    logic [c3r_pkg::ACC_W-1:0]    shifted;

    c3r_ram #(.DATA_W(8), .DEPTH(c3r_pkg::NGROUPS * c3r_pkg::TAPS)) u_wram (
        .i_clk   (i_clk),
        .i_we    (i_wr.we_w),
        .i_waddr (i_wr.waddr),
        .i_wdata (i_wr.wdata),
        .i_raddr (i_raddr_w),
        .o_rdata (w_rdata)
    );

    c3r_ram #(.DATA_W(c3r_pkg::ACC_W), .DEPTH(c3r_pkg::NGROUPS)) u_bram (
        .i_clk   (i_clk),
        .i_we    (i_wr.we_b),
        .i_waddr (i_wr.baddr),
        .i_wdata (i_wr.bdata),
        .i_raddr (i_raddr_b),
        .o_rdata (b_rdata)
    );

    always_comb begin
        prod   = i_ctl.sample * $signed(w_rdata);
        addend = i_ctl.tap_ok ? c3r_pkg::ACC_W'(prod) : '0;
        n_acc  = (i_ctl.first ? b_rdata : r_acc) + addend;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_acc <= n_acc;
        end
    end

    // negative sums clamp to zero, so the shift can be logical
    always_comb begin
        shifted = r_acc >> i_shift;
        if (r_acc[c3r_pkg::ACC_W-1]) begin
            o_act = '0;
        end else if (shifted > c3r_pkg::ACC_W'(c3r_pkg::ACT_MAX)) begin
            o_act = c3r_pkg::ACT_MAX;
        end else begin
            o_act = shifted[c3r_pkg::ACT_W-1:0];
        end
    end

endmodule

// File: hw/rtl/c3r_merge.sv
// Result stage: gathers the lane activations into one result item and holds it
// in the output register until taken. Depends on c3r_pkg, c3r_if.
module c3r_merge (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  c3r_pkg::t_res_info        i_info,
    input  logic [c3r_pkg::ACT_W-1:0] i_act [c3r_pkg::LANES],
    c3r_out_if.source                 o_res
);

    logic                      r_valid;
    logic [c3r_pkg::POS_W-1:0] r_row;
    logic [c3r_pkg::POS_W-1:0] r_col;
    logic [c3r_pkg::CG_W-1:0]  r_grp;
    logic                      r_last;
    logic [c3r_pkg::ACT_W-1:0] r_lane [c3r_pkg::OUT_LANES];
    logic [c3r_pkg::ACT_W-1:0] n_lane [c3r_pkg::OUT_LANES];

    // fields with no channel behind them read as zero
    always_comb begin
        for (int l = 0; l < c3r_pkg::OUT_LANES; l++) begin
            n_lane[l] = '0;
            if (l < c3r_pkg::LANES) begin
                if (int'(i_info.grp) * c3r_pkg::LANES + l < c3r_pkg::OUT_CHANNELS) begin
                    n_lane[l] = i_act[l % c3r_pkg::LANES];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_info.fin) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_info.fin) begin
            r_row  <= i_info.row;
            r_col  <= i_info.col;
            r_grp  <= c3r_pkg::CG_W'(i_info.grp);
            r_last <= i_info.last;
            r_lane <= n_lane;
        end
    end

    assign o_res.valid      = r_valid;
    assign o_res.out_row    = r_row;
    assign o_res.out_col    = r_col;
    assign o_res.chan_group = r_grp;
    assign o_res.run_last   = r_last;
    assign o_res.lane0      = r_lane[0];
    assign o_res.lane1      = r_lane[1];
    assign o_res.lane2      = r_lane[2];
    assign o_res.lane3      = r_lane[3];
    assign o_res.lane4      = r_lane[4];
    assign o_res.lane5      = r_lane[5];
    assign o_res.lane6      = r_lane[6];
    assign o_res.lane7      = r_lane[7];

endmodule

// File: hw/rtl/c3r_checker.sv
// Port-level checks for the convolution block, attached to the top level by
// bind. Depends on the top level's interface ports.
module c3r_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [4:0] i_out_row,
    input logic [4:0] i_out_col,
    input logic [1:0] i_out_grp,
    input logic [6:0] i_out_lane0,
    input logic       i_out_last
);

    // a result waits until it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped before it was taken");

    // a waiting result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_row) && $stable(i_out_col)
            && $stable(i_out_grp) && $stable(i_out_lane0) && $stable(i_out_last))
        else $error("waiting result changed");

    // no result straight out of reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // more results of the same pixel are due, so no new item may enter
    a_busy_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_last |-> !i_in_ready)
        else $error("item accepted in the middle of a pixel's results");

endmodule

bind int8_conv3x3_relu_stream c3r_checker u_c3r_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_row   (o_res.out_row),
    .i_out_col   (o_res.out_col),
    .i_out_grp   (o_res.chan_group),
    .i_out_lane0 (o_res.lane0),
    .i_out_last  (o_res.run_last)
);
